### design/pdc_pkg.sv
// Shared types, constants and the CRC step for the packet deframer.
package pdc_pkg;

  localparam int MAX_PAYLOAD = 64;
  localparam int COUNT_W = $clog2(MAX_PAYLOAD + 1);
  localparam logic [7:0] LEN_LIMIT = 8'(MAX_PAYLOAD);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Result item kinds
  localparam logic ITEM_PAYLOAD = 1'b0;
  localparam logic ITEM_STATUS  = 1'b1;

  // Packet status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_BAD_CRC = 2'd1;
  localparam logic [1:0] STATUS_BAD_LEN = 2'd2;

  // Command kinds
  localparam logic [2:0] KIND_NONE     = 3'd0;
  localparam logic [2:0] KIND_SET_ADDR = 3'd1;
  localparam logic [2:0] KIND_SET_BAUD = 3'd2;
  localparam logic [2:0] KIND_SET_MODE = 3'd3;
  localparam logic [2:0] KIND_READ_VAL = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] REG_OWN_ADDR_HIGH   = 3'd0;
  localparam logic [2:0] REG_OWN_ADDR_LOW    = 3'd1;
  localparam logic [2:0] REG_START_BYTE      = 3'd2;
  localparam logic [2:0] REG_CMD_SET_ADDRESS = 3'd3;
  localparam logic [2:0] REG_CMD_SET_BAUD    = 3'd4;
  localparam logic [2:0] REG_CMD_SET_MODE    = 3'd5;
  localparam logic [2:0] REG_CMD_READ_VALUES = 3'd6;

  typedef struct packed {
    logic [7:0] own_addr_high;
    logic [7:0] own_addr_low;
    logic [7:0] start_byte;
    logic [7:0] cmd_set_address;
    logic [7:0] cmd_set_baud;
    logic [7:0] cmd_set_mode;
    logic [7:0] cmd_read_values;
  } cfg_t;

  typedef struct packed {
    logic       item_kind;
    logic [7:0] payload_byte;
    logic [5:0] payload_index;
    logic [1:0] packet_status;
    logic       addressed_to_us;
    logic       nak_needed;
    logic [7:0] command_code;
    logic [2:0] command_kind;
    logic [7:0] frame_length;
    logic       last_item;
  } result_t;

  // One byte of CRC-16/CCITT-FALSE, MSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

### design/packet_deframer_crc16_check.sv
// Top level of the packet deframer with CRC-16/CCITT-FALSE check.
//
//   channel  direction  handshake             payload
//   in       receive    in_valid / in_stall   rx_byte
//   out      send       out_valid / out_stall item_kind .. last_item
//   cfg      receive    cfg_valid / cfg_ready cfg_index, cfg_data
//
// One received byte per cycle while in_stall is low; the parser updates its state and the CRC
// (one byte step) in the cycle the beat is accepted, and any result is registered in a
// two-entry output buffer.
// in_stall rises only while both buffer entries hold untaken results.
// Synchronous reset returns the parser to hunting and the registers to defaults.
module packet_deframer_crc16_check (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       item_kind,
  output logic [7:0] payload_byte,
  output logic [5:0] payload_index,
  output logic [1:0] packet_status,
  output logic       addressed_to_us,
  output logic       nak_needed,
  output logic [7:0] command_code,
  output logic [2:0] command_kind,
  output logic [7:0] frame_length,
  output logic       last_item,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);

  pdc_pkg::cfg_t    cfg;
  pdc_pkg::result_t res, head;
  logic             res_valid;
  logic             full;
  logic             take;

  assign in_stall = full;
  assign take     = in_valid && !in_stall;

  pdc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pdc_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .rx_byte   (rx_byte),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  pdc_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign item_kind       = head.item_kind;
  assign payload_byte    = head.payload_byte;
  assign payload_index   = head.payload_index;
  assign packet_status   = head.packet_status;
  assign addressed_to_us = head.addressed_to_us;
  assign nak_needed      = head.nak_needed;
  assign command_code    = head.command_code;
  assign command_kind    = head.command_kind;
  assign frame_length    = head.frame_length;
  assign last_item       = head.last_item;

endmodule

### design/pdc_cfg.sv
// Configuration register file of the packet deframer.
module pdc_cfg (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [7:0]    cfg_data,
  output pdc_pkg::cfg_t cfg
);

  pdc_pkg::cfg_t regs;

  assign cfg_ready = 1'b1;
  assign cfg = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.own_addr_high   <= 8'd0;
      regs.own_addr_low    <= 8'd0;
      regs.start_byte      <= 8'd126;
      regs.cmd_set_address <= 8'd161;
      regs.cmd_set_baud    <= 8'd162;
      regs.cmd_set_mode    <= 8'd163;
      regs.cmd_read_values <= 8'd164;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pdc_pkg::REG_OWN_ADDR_HIGH:   regs.own_addr_high   <= cfg_data;
        pdc_pkg::REG_OWN_ADDR_LOW:    regs.own_addr_low    <= cfg_data;
        pdc_pkg::REG_START_BYTE:      regs.start_byte      <= cfg_data;
        pdc_pkg::REG_CMD_SET_ADDRESS: regs.cmd_set_address <= cfg_data;
        pdc_pkg::REG_CMD_SET_BAUD:    regs.cmd_set_baud    <= cfg_data;
        pdc_pkg::REG_CMD_SET_MODE:    regs.cmd_set_mode    <= cfg_data;
        pdc_pkg::REG_CMD_READ_VALUES: regs.cmd_read_values <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

### design/pdc_parser.sv
// Frame parser: state machine, running CRC and result formation per byte.
module pdc_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  logic [7:0]       rx_byte,
  input  pdc_pkg::cfg_t    cfg,
  output logic             res_valid,
  output pdc_pkg::result_t res
);

  localparam logic [2:0] ST_HUNT      = 3'd0;
  localparam logic [2:0] ST_ADDR_HIGH = 3'd1;
  localparam logic [2:0] ST_ADDR_LOW  = 3'd2;
  localparam logic [2:0] ST_LEN       = 3'd3;
  localparam logic [2:0] ST_CMD       = 3'd4;
  localparam logic [2:0] ST_DATA      = 3'd5;
  localparam logic [2:0] ST_CRC_HIGH  = 3'd6;
  localparam logic [2:0] ST_CRC_LOW   = 3'd7;

  logic [2:0]                  state, state_next;
  logic [7:0]                  addr_high_seen, addr_high_seen_next;
  logic [7:0]                  addr_low_seen, addr_low_seen_next;
  logic [7:0]                  length_seen, length_seen_next;
  logic [7:0]                  command_seen, command_seen_next;
  logic [2:0]                  kind_seen, kind_seen_next;
  logic [pdc_pkg::COUNT_W-1:0] payload_count, payload_count_next;
  logic [15:0]                 running_crc, running_crc_next;
  logic [7:0]                  crc_high_seen, crc_high_seen_next;

  logic [15:0]                 crc_step;
  logic [2:0]                  rx_kind;
  logic                        ours;
  logic [pdc_pkg::COUNT_W-1:0] count_inc;

  assign crc_step  = pdc_pkg::crc_byte(running_crc, rx_byte);
  assign ours      = (addr_high_seen == cfg.own_addr_high) &&
                     (addr_low_seen == cfg.own_addr_low);
  assign count_inc = payload_count + {{(pdc_pkg::COUNT_W-1){1'b0}}, 1'b1};

  // Lowest kind wins when command registers are equal
  always_comb begin
    if (rx_byte == cfg.cmd_set_address)      rx_kind = pdc_pkg::KIND_SET_ADDR;
    else if (rx_byte == cfg.cmd_set_baud)    rx_kind = pdc_pkg::KIND_SET_BAUD;
    else if (rx_byte == cfg.cmd_set_mode)    rx_kind = pdc_pkg::KIND_SET_MODE;
    else if (rx_byte == cfg.cmd_read_values) rx_kind = pdc_pkg::KIND_READ_VAL;
    else                                     rx_kind = pdc_pkg::KIND_NONE;
  end

  always_comb begin
    state_next          = state;
    addr_high_seen_next = addr_high_seen;
    addr_low_seen_next  = addr_low_seen;
    length_seen_next    = length_seen;
    command_seen_next   = command_seen;
    kind_seen_next      = kind_seen;
    payload_count_next  = payload_count;
    running_crc_next    = running_crc;
    crc_high_seen_next  = crc_high_seen;

    res_valid           = 1'b0;
    res.item_kind       = pdc_pkg::ITEM_STATUS;
    res.payload_byte    = 8'd0;
    res.payload_index   = 6'd0;
    res.packet_status   = pdc_pkg::STATUS_OK;
    res.addressed_to_us = ours;
    res.nak_needed      = 1'b0;
    res.command_code    = command_seen;
    res.command_kind    = kind_seen;
    res.frame_length    = length_seen;
    res.last_item       = 1'b1;

    if (take) begin
      case (state)
        ST_HUNT: begin
          if (rx_byte == cfg.start_byte) begin
            running_crc_next = pdc_pkg::crc_byte(pdc_pkg::CRC_INIT, rx_byte);
            state_next       = ST_ADDR_HIGH;
          end
        end
        ST_ADDR_HIGH: begin
          addr_high_seen_next = rx_byte;
          running_crc_next    = crc_step;
          state_next          = ST_ADDR_LOW;
        end
        ST_ADDR_LOW: begin
          addr_low_seen_next = rx_byte;
          running_crc_next   = crc_step;
          state_next         = ST_LEN;
        end
        ST_LEN: begin
          length_seen_next = rx_byte;
          running_crc_next = crc_step;
          if (rx_byte > pdc_pkg::LEN_LIMIT) begin
            // Drop the packet at once and report it
            res_valid         = 1'b1;
            res.packet_status = pdc_pkg::STATUS_BAD_LEN;
            res.nak_needed    = ours;
            res.command_code  = 8'd0;
            res.command_kind  = pdc_pkg::KIND_NONE;
            res.frame_length  = rx_byte;
            state_next        = ST_HUNT;
          end else begin
            payload_count_next = '0;
            state_next         = ST_CMD;
          end
        end
        ST_CMD: begin
          command_seen_next = rx_byte;
          running_crc_next  = crc_step;
          kind_seen_next    = rx_kind;
          if (rx_kind != pdc_pkg::KIND_NONE && length_seen != 8'd0) state_next = ST_DATA;
          else                                                      state_next = ST_CRC_HIGH;
        end
        ST_DATA: begin
          running_crc_next   = crc_step;
          res_valid          = 1'b1;
          res.item_kind      = pdc_pkg::ITEM_PAYLOAD;
          res.payload_byte   = rx_byte;
          res.payload_index  = 6'(payload_count);
          res.last_item      = 1'b0;
          payload_count_next = count_inc;
          if (8'(count_inc) >= length_seen) state_next = ST_CRC_HIGH;
        end
        ST_CRC_HIGH: begin
          crc_high_seen_next = rx_byte;
          state_next         = ST_CRC_LOW;
        end
        ST_CRC_LOW: begin
          res_valid = 1'b1;
          if ({crc_high_seen, rx_byte} != running_crc) begin
            res.packet_status = pdc_pkg::STATUS_BAD_CRC;
            res.nak_needed    = ours;
          end
          state_next = ST_HUNT;
        end
        default: state_next = ST_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_HUNT;
      addr_high_seen <= 8'd0;
      addr_low_seen  <= 8'd0;
      length_seen    <= 8'd0;
      command_seen   <= 8'd0;
      kind_seen      <= pdc_pkg::KIND_NONE;
      payload_count  <= '0;
      running_crc    <= pdc_pkg::CRC_INIT;
      crc_high_seen  <= 8'd0;
    end else begin
      state          <= state_next;
      addr_high_seen <= addr_high_seen_next;
      addr_low_seen  <= addr_low_seen_next;
      length_seen    <= length_seen_next;
      command_seen   <= command_seen_next;
      kind_seen      <= kind_seen_next;
      payload_count  <= payload_count_next;
      running_crc    <= running_crc_next;
      crc_high_seen  <= crc_high_seen_next;
    end
  end

  a_payload_only_in_data: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.item_kind == pdc_pkg::ITEM_PAYLOAD |-> state == ST_DATA)
    else $error("payload beat produced outside the data phase");

  a_status_then_hunt: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.item_kind == pdc_pkg::ITEM_STATUS |=> state == ST_HUNT)
    else $error("parser did not return to hunting after a status beat");

  a_bad_len_reported: assert property (@(posedge clk) disable iff (rst)
    take && state == ST_LEN && rx_byte > pdc_pkg::LEN_LIMIT |->
      res_valid && res.packet_status == pdc_pkg::STATUS_BAD_LEN)
    else $error("oversized length byte not reported");

endmodule

### design/pdc_outbuf.sv
// Two-entry output buffer: result register plus skid slot.
module pdc_outbuf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  pdc_pkg::result_t push_data,
  output logic             full,
  output logic             out_valid,
  input  logic             out_stall,
  output pdc_pkg::result_t head
);

  logic [1:0]       count, count_next;
  pdc_pkg::result_t slot0, slot1;
  logic             pop;

  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign head      = slot0;
  assign pop       = out_valid && !out_stall;

  always_comb begin
    count_next = count;
    if (push && !pop)      count_next = count + 2'd1;
    else if (pop && !push) count_next = count - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) count <= 2'd0;
    else     count <= count_next;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      // Advance the skid slot into the head, or the pushed result when the head is the only entry
      if (push && count == 2'd1) slot0 <= push_data;
      else                       slot0 <= slot1;
      if (push && count == 2'd2) slot1 <= push_data;
    end else if (push) begin
      if (count == 2'd0) slot0 <= push_data;
      else               slot1 <= push_data;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("output buffer count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("beat pushed into a full output buffer");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    pop && !push && count == 2'd1 |=> !out_valid)
    else $error("output buffer did not drain");

endmodule

### sim/deframe_checker.sv
// Checker for the packet deframer: follows every beat, predicts results, compares them in order.
module deframe_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       item_kind,
  input  logic [7:0] payload_byte,
  input  logic [5:0] payload_index,
  input  logic [1:0] packet_status,
  input  logic       addressed_to_us,
  input  logic       nak_needed,
  input  logic [7:0] command_code,
  input  logic [2:0] command_kind,
  input  logic [7:0] frame_length,
  input  logic       last_item,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  output int         mismatches,
  output int         results_due
);

  localparam int REPORT_LIMIT = 10;
  localparam pdc_pkg::cfg_t REGS_AT_RESET =
    {8'd0, 8'd0, 8'd126, 8'd161, 8'd162, 8'd163, 8'd164};

  typedef enum logic [2:0] {
    PS_HUNT,
    PS_ADDR_HIGH,
    PS_ADDR_LOW,
    PS_LENGTH,
    PS_COMMAND,
    PS_PAYLOAD,
    PS_CRC_HIGH,
    PS_CRC_LOW
  } parse_e;

  pdc_pkg::cfg_t    regs;
  parse_e           pstate;
  logic [7:0]       addr_hi_q;
  logic [7:0]       addr_lo_q;
  logic [7:0]       len_q;
  logic [7:0]       cmd_q;
  logic [7:0]       crc_hi_q;
  logic [2:0]       kind_q;
  logic [6:0]       count_q;
  logic [15:0]      crc_q;
  pdc_pkg::result_t due_items[$];

  // Shift the byte in one bit at a time, MSB first
  function automatic logic [15:0] crc16_ccitt(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    int          i;
    c = crc;
    for (i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c  = {c[14:0], 1'b0} ^ (fb ? pdc_pkg::CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  // Lowest kind wins when several command registers hold the same code
  function automatic logic [2:0] kind_for(input logic [7:0] cmd);
    if (cmd == regs.cmd_set_address) return pdc_pkg::KIND_SET_ADDR;
    if (cmd == regs.cmd_set_baud) return pdc_pkg::KIND_SET_BAUD;
    if (cmd == regs.cmd_set_mode) return pdc_pkg::KIND_SET_MODE;
    if (cmd == regs.cmd_read_values) return pdc_pkg::KIND_READ_VAL;
    return pdc_pkg::KIND_NONE;
  endfunction

  function automatic logic addr_match();
    return (addr_hi_q == regs.own_addr_high) && (addr_lo_q == regs.own_addr_low);
  endfunction

  function automatic pdc_pkg::result_t status_item(input logic [1:0] st,
                                                   input logic [7:0] cmd,
                                                   input logic [2:0] kind);
    pdc_pkg::result_t r;
    r                 = '0;
    r.item_kind       = pdc_pkg::ITEM_STATUS;
    r.packet_status   = st;
    r.addressed_to_us = addr_match();
    r.nak_needed      = addr_match() && (st != pdc_pkg::STATUS_OK);
    r.command_code    = cmd;
    r.command_kind    = kind;
    r.frame_length    = len_q;
    r.last_item       = 1'b1;
    return r;
  endfunction

  task automatic parse_rx_byte(input logic [7:0] b, output bit made,
                               output pdc_pkg::result_t r);
    made = 1'b0;
    r    = '0;
    case (pstate)
      PS_HUNT: begin
        if (b == regs.start_byte) begin
          crc_q  = crc16_ccitt(pdc_pkg::CRC_INIT, b);
          pstate = PS_ADDR_HIGH;
        end
      end
      PS_ADDR_HIGH: begin
        addr_hi_q = b;
        crc_q     = crc16_ccitt(crc_q, b);
        pstate    = PS_ADDR_LOW;
      end
      PS_ADDR_LOW: begin
        addr_lo_q = b;
        crc_q     = crc16_ccitt(crc_q, b);
        pstate    = PS_LENGTH;
      end
      PS_LENGTH: begin
        len_q = b;
        crc_q = crc16_ccitt(crc_q, b);
        if (b > pdc_pkg::LEN_LIMIT) begin
          // drop the packet right here
          r      = status_item(pdc_pkg::STATUS_BAD_LEN, 8'h00, pdc_pkg::KIND_NONE);
          made   = 1'b1;
          pstate = PS_HUNT;
        end else begin
          count_q = '0;
          pstate  = PS_COMMAND;
        end
      end
      PS_COMMAND: begin
        cmd_q  = b;
        crc_q  = crc16_ccitt(crc_q, b);
        kind_q = kind_for(b);
        pstate = (kind_q != pdc_pkg::KIND_NONE && len_q != 8'd0) ? PS_PAYLOAD : PS_CRC_HIGH;
      end
      PS_PAYLOAD: begin
        crc_q             = crc16_ccitt(crc_q, b);
        r.item_kind       = pdc_pkg::ITEM_PAYLOAD;
        r.payload_byte    = b;
        r.payload_index   = count_q[5:0];
        r.addressed_to_us = addr_match();
        r.command_code    = cmd_q;
        r.command_kind    = kind_q;
        r.frame_length    = len_q;
        made              = 1'b1;
        count_q           = count_q + 7'd1;
        if (8'(count_q) >= len_q) pstate = PS_CRC_HIGH;
      end
      PS_CRC_HIGH: begin
        crc_hi_q = b;
        pstate   = PS_CRC_LOW;
      end
      PS_CRC_LOW: begin
        r = status_item(({crc_hi_q, b} == crc_q) ? pdc_pkg::STATUS_OK : pdc_pkg::STATUS_BAD_CRC,
                        cmd_q, kind_q);
        made   = 1'b1;
        pstate = PS_HUNT;
      end
      default: ;
    endcase
  endtask

  function automatic string show(input pdc_pkg::result_t r);
    return $sformatf("kind=%0d byte=%02h index=%0d status=%0d ours=%0d nak=%0d cmd=%02h %s",
                     r.item_kind, r.payload_byte, r.payload_index, r.packet_status,
                     r.addressed_to_us, r.nak_needed, r.command_code,
                     $sformatf("ckind=%0d len=%0d last=%0d", r.command_kind,
                               r.frame_length, r.last_item));
  endfunction

  task automatic log_mismatch(input string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("%s", msg);
  endtask

  always @(posedge clk) begin : watch
    pdc_pkg::result_t got;
    pdc_pkg::result_t want;
    bit               made;
    if (rst) begin
      regs      = REGS_AT_RESET;
      pstate    = PS_HUNT;
      addr_hi_q = '0;
      addr_lo_q = '0;
      len_q     = '0;
      cmd_q     = '0;
      kind_q    = pdc_pkg::KIND_NONE;
      count_q   = '0;
      crc_q     = pdc_pkg::CRC_INIT;
      crc_hi_q  = '0;
      due_items.delete();
      mismatches = 0;
    end else begin
      // a result leaving now always belongs to an earlier byte, so check before predicting
      if (out_valid && !out_stall) begin
        got = {item_kind, payload_byte, payload_index, packet_status, addressed_to_us,
               nak_needed, command_code, command_kind, frame_length, last_item};
        if (due_items.size() == 0) begin
          log_mismatch($sformatf("unexpected result: %s", show(got)));
        end else begin
          want = due_items.pop_front();
          if (got !== want)
            log_mismatch($sformatf("result mismatch\n  expected %s\n  actual   %s",
                                   show(want), show(got)));
        end
      end
      // a byte taken at this edge still sees the registers from before it
      if (in_valid && !in_stall) begin
        parse_rx_byte(rx_byte, made, want);
        if (made) due_items.push_back(want);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pdc_pkg::REG_OWN_ADDR_HIGH:   regs.own_addr_high   = cfg_data;
          pdc_pkg::REG_OWN_ADDR_LOW:    regs.own_addr_low    = cfg_data;
          pdc_pkg::REG_START_BYTE:      regs.start_byte      = cfg_data;
          pdc_pkg::REG_CMD_SET_ADDRESS: regs.cmd_set_address = cfg_data;
          pdc_pkg::REG_CMD_SET_BAUD:    regs.cmd_set_baud    = cfg_data;
          pdc_pkg::REG_CMD_SET_MODE:    regs.cmd_set_mode    = cfg_data;
          pdc_pkg::REG_CMD_READ_VALUES: regs.cmd_read_values = cfg_data;
          default: ;
        endcase
      end
    end
    results_due = due_items.size();
  end

endmodule

### sim/tb_packet_deframer_crc16_check.sv
// Top of the deframer bench: clock, reset, frame and register stimulus, watchdog and verdict.
module tb_packet_deframer_crc16_check;

  localparam int HALF_PERIOD    = 6;
  localparam int RESET_CYCLES   = 10;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_ITEMS    = 108;
  localparam int PHASES         = 6;
  localparam int FLUSH_BYTES    = pdc_pkg::MAX_PAYLOAD + 8;
  localparam int DRAIN_SETTLE   = 4;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic [7:0] rx_byte   = 8'h00;
  logic       out_stall = 1'b0;
  logic       cfg_valid = 1'b0;
  logic [2:0] cfg_index = pdc_pkg::REG_OWN_ADDR_HIGH;
  logic [7:0] cfg_data  = 8'h00;

  logic       in_stall;
  logic       out_valid;
  logic       item_kind;
  logic [7:0] payload_byte;
  logic [5:0] payload_index;
  logic [1:0] packet_status;
  logic       addressed_to_us;
  logic       nak_needed;
  logic [7:0] command_code;
  logic [2:0] command_kind;
  logic [7:0] frame_length;
  logic       last_item;
  logic       cfg_ready;

  int            mismatches;
  int            results_due;
  int            idle_cycles = 0;
  int            items_sent  = 0;
  bit            calm        = 1'b0;
  bit            dirty       = 1'b0;
  pdc_pkg::cfg_t link_cfg;

  packet_deframer_crc16_check dut (
    .clk, .rst, .in_valid, .in_stall, .rx_byte, .out_valid, .out_stall,
    .item_kind, .payload_byte, .payload_index, .packet_status, .addressed_to_us,
    .nak_needed, .command_code, .command_kind, .frame_length, .last_item,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  deframe_checker checker_i (
    .clk, .rst, .in_valid, .in_stall, .rx_byte, .out_valid, .out_stall,
    .item_kind, .payload_byte, .payload_index, .packet_status, .addressed_to_us,
    .nak_needed, .command_code, .command_kind, .frame_length, .last_item,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .mismatches, .results_due
  );

  always #HALF_PERIOD clk = ~clk;

  // Mostly short gaps, now and then a long one, none during calm stretches
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 45);
  endfunction

  initial begin : stall_gen
    int n;
    forever begin
      n = pick_gap();
      if (n > 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Hold the sender until every predicted result has left the block
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (DRAIN_SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_regs(input pdc_pkg::cfg_t c);
    // bytes that are never the start byte walk any half-parsed packet back to hunting
    if (dirty) begin
      repeat (FLUSH_BYTES) send_byte(~link_cfg.start_byte);
      dirty = 1'b0;
    end
    drain();
    write_reg(pdc_pkg::REG_OWN_ADDR_HIGH, c.own_addr_high);
    write_reg(pdc_pkg::REG_OWN_ADDR_LOW, c.own_addr_low);
    write_reg(pdc_pkg::REG_START_BYTE, c.start_byte);
    write_reg(pdc_pkg::REG_CMD_SET_ADDRESS, c.cmd_set_address);
    write_reg(pdc_pkg::REG_CMD_SET_BAUD, c.cmd_set_baud);
    write_reg(pdc_pkg::REG_CMD_SET_MODE, c.cmd_set_mode);
    write_reg(pdc_pkg::REG_CMD_READ_VALUES, c.cmd_read_values);
    @(negedge clk);
    cfg_valid <= 1'b0;
    link_cfg = c;
  endtask

  // Build one frame under the current registers; cut > 0 truncates it to that many beats
  task automatic send_frame(input logic [7:0] ah, input logic [7:0] al, input logic [7:0] len,
                            input logic [7:0] cmd, input bit bad_crc, input int cut);
    logic [7:0]  frame_q[$];
    logic [15:0] crc;
    bit          with_data;
    frame_q = {link_cfg.start_byte, ah, al, len};
    if (len <= pdc_pkg::LEN_LIMIT) begin
      with_data = (cmd == link_cfg.cmd_set_address) || (cmd == link_cfg.cmd_set_baud) ||
                  (cmd == link_cfg.cmd_set_mode) || (cmd == link_cfg.cmd_read_values);
      frame_q.push_back(cmd);
      if (with_data) repeat (len) frame_q.push_back(8'($urandom));
      crc = pdc_pkg::CRC_INIT;
      foreach (frame_q[i]) crc = pdc_pkg::crc_byte(crc, frame_q[i]);
      if (bad_crc) crc ^= 16'(1 << $urandom_range(0, 15));
      frame_q.push_back(crc[15:8]);
      frame_q.push_back(crc[7:0]);
    end
    if (cut > 0 && cut < frame_q.size()) begin
      frame_q = frame_q[0:cut-1];
      dirty   = 1'b1;
    end
    foreach (frame_q[i]) send_byte(frame_q[i]);
  endtask

  task automatic random_packet();
    logic [7:0] ah;
    logic [7:0] al;
    logic [7:0] len;
    logic [7:0] cmd;
    int         r;
    r    = $urandom_range(0, 99);
    calm = ($urandom_range(0, 7) == 0);
    ah   = ($urandom_range(0, 9) < 7) ? link_cfg.own_addr_high : 8'($urandom);
    al   = ($urandom_range(0, 9) < 7) ? link_cfg.own_addr_low : 8'($urandom);
    case ($urandom_range(0, 4))
      0: cmd = link_cfg.cmd_set_address;
      1: cmd = link_cfg.cmd_set_baud;
      2: cmd = link_cfg.cmd_set_mode;
      3: cmd = link_cfg.cmd_read_values;
      default: cmd = 8'($urandom);
    endcase
    case ($urandom_range(0, 19))
      0: len = 8'd0;
      1: len = pdc_pkg::LEN_LIMIT;
      2: len = 8'($urandom_range(21, pdc_pkg::MAX_PAYLOAD));
      3: len = 8'($urandom_range(9, 20));
      default: len = 8'($urandom_range(1, 8));
    endcase
    if (r < 72) begin
      send_frame(ah, al, len, cmd, 1'b0, 0);
    end else if (r < 82) begin
      send_frame(ah, al, len, cmd, 1'b1, 0);
    end else if (r < 89) begin
      send_frame(ah, al, 8'($urandom_range(pdc_pkg::MAX_PAYLOAD + 1, 255)), cmd, 1'b0, 0);
    end else if (r < 95) begin
      // line noise, sometimes carrying a stray start byte
      repeat ($urandom_range(1, 5))
        send_byte(($urandom_range(0, 3) == 0) ? link_cfg.start_byte : 8'($urandom));
      dirty = 1'b1;
    end else begin
      send_frame(ah, al, len, cmd, 1'b0, $urandom_range(1, 6));
    end
    if ($urandom_range(0, 49) == 0) drain();
  endtask

  initial begin : stimulus
    pdc_pkg::cfg_t phase_cfg;
    int            p;
    logic [7:0]    c0;
    logic [7:0]    c1;
    link_cfg = {8'd0, 8'd0, 8'd126, 8'd161, 8'd162, 8'd163, 8'd164};
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed frames under the reset registers
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(8'h00, 8'h00, pdc_pkg::LEN_LIMIT + 8'd1, link_cfg.cmd_set_address, 1'b0, 0);
    send_frame(8'h00, 8'h00, 8'd0, link_cfg.cmd_set_baud, 1'b0, 0);
    send_frame(8'hFF, 8'hFF, 8'd3, 8'h55, 1'b0, 0);
    send_frame(8'h00, 8'h00, 8'd1, link_cfg.cmd_read_values, 1'b1, 0);

    for (p = 0; p < PHASES; p++) begin
      c0 = 8'($urandom);
      c1 = 8'($urandom);
      case (p)
        0: phase_cfg = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        1: phase_cfg = {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        2: phase_cfg = {8'($urandom), 8'($urandom), 8'($urandom), c0, c0, c1, c1};
        default: phase_cfg = pdc_pkg::cfg_t'(56'({$urandom, $urandom}));
      endcase
      load_regs(phase_cfg);
      while (items_sent < (p + 1) * PHASE_ITEMS) random_packet();
    end

    calm = 1'b0;
    drain();
    if (mismatches == 0 && results_due == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
